// ===== rtl/scdo_pkg.sv =====
// Shared types and constants of the segment crack disk occlusion block.
// Used by the interfaces, the entry cells, the disk test unit and the top level.
package scdo_pkg;

  localparam int unsigned FracBits   = 16;
  localparam int unsigned LambdaBits = 30;
  localparam int unsigned IndexW     = 6;
  localparam int unsigned CountW     = 7;

  typedef enum logic [1:0] {
    CMD_WR_POS    = 2'd0,
    CMD_WR_NRM    = 2'd1,
    CMD_SET_START = 2'd2,
    CMD_QUERY     = 2'd3
  } cmd_e;

  // three Q16.16 components, index 0 is x
  typedef logic [2:0][31:0] vec_t;

  typedef struct packed {
    vec_t        pos;
    vec_t        nrm;
    logic [30:0] radius;
    logic [31:0] offset;
    logic        broken;
  } entry_t;

  typedef struct packed {
    logic done;
    logic blocks;
  } test_rsp_t;

endpackage

// ===== rtl/scdo_if.sv =====
// Valid/ready channel interfaces for command items and query results.
// Depends on scdo_pkg for the field widths.
interface scdo_in_if;
  import scdo_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          command;
  logic [IndexW-1:0]   entry_index;
  logic [CountW-1:0]   test_count;
  logic signed [31:0]  vec_x;
  logic signed [31:0]  vec_y;
  logic signed [31:0]  vec_z;
  logic [30:0]         crack_radius_in;
  logic signed [31:0]  crack_offset_in;
  logic                broken_in;

  modport source (output valid, command, entry_index, test_count, vec_x, vec_y, vec_z,
                  crack_radius_in, crack_offset_in, broken_in, input ready);
  modport sink   (input valid, command, entry_index, test_count, vec_x, vec_y, vec_z,
                  crack_radius_in, crack_offset_in, broken_in, output ready);
endinterface

interface scdo_out_if;
  import scdo_pkg::*;
  logic              valid;
  logic              ready;
  logic              is_visible;
  logic [IndexW-1:0] blocking_entry;

  modport source (output valid, is_visible, blocking_entry, input ready);
  modport sink   (input valid, is_visible, blocking_entry, output ready);
endinterface

// ===== rtl/scdo_cell.sv =====
// One cell of the rotating entry chain: holds one crack entry.
// Depends on scdo_pkg for entry_t.
module scdo_cell import scdo_pkg::*; (
  input  logic   clk_i,
  input  logic   shift_i,
  input  entry_t next_i,
  input  logic   wr_pos_i,
  input  logic   wr_nrm_i,
  input  entry_t wdata_i,
  output entry_t entry_o
);

  entry_t entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    if (shift_i) begin
      entry_d = next_i;
    end else if (wr_pos_i) begin
      entry_d.pos    = wdata_i.pos;
      entry_d.radius = wdata_i.radius;
      entry_d.offset = wdata_i.offset;
      entry_d.broken = wdata_i.broken;
    end else if (wr_nrm_i) begin
      entry_d.nrm = wdata_i.nrm;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== rtl/scdo_test.sv =====
// Multi-cycle segment against crack disk test; one shared multiplier forms most of its products.
// Depends on scdo_pkg.
module scdo_test import scdo_pkg::*; #(
  parameter int unsigned CentreW = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  entry_t    entry_i,
  input  vec_t      seg_a_i,
  input  vec_t      seg_b_i,
  output test_rsp_t rsp_o
);

  typedef enum logic [7:0] {
    T_IDLE = 8'b0000_0001,
    T_CEN  = 8'b0000_0010,
    T_DOT  = 8'b0000_0100,
    T_CHK  = 8'b0000_1000,
    T_DIV  = 8'b0001_0000,
    T_LAM  = 8'b0010_0000,
    T_LEN  = 8'b0100_0000,
    T_END  = 8'b1000_0000
  } tstate_e;

  localparam logic signed [49:0] SatHi = (50'sd1 <<< (CentreW - 1)) - 50'sd1;
  localparam logic signed [49:0] SatLo = -SatHi - 50'sd1;
  localparam logic [4:0]  DivLast = 5'(LambdaBits - 1);
  localparam logic [30:0] LamOne  = 31'(1) << LambdaBits;

  tstate_e st_q, st_d;
  logic [2:0] s_q, s_d;
  logic [4:0] it_q, it_d;

  entry_t             e_q;
  logic signed [67:0] p_q;
  logic signed [32:0] dv_q [3];
  logic signed [31:0] dd_q [3];
  logic signed [51:0] a_q, b_q;
  logic [51:0]        rem_q;
  logic [30:0]        lam_q;
  logic               ovf_q, blk_q;
  logic [63:0]        len_q;
  logic [61:0]        r2_q;

  logic signed [33:0] op_a, op_b;
  logic [1:0]         ci, di;
  logic signed [49:0] cen_sum;
  logic signed [31:0] cen_o;
  logic signed [32:0] dv_new;
  logic signed [51:0] dot_term;
  logic signed [39:0] lam_d;
  logic signed [51:0] an, bn;
  logic [51:0]        rem2;
  logic [2:0]         s_dec;

  assign s_dec = s_q - 3'd1;
  assign ci    = s_dec[1:0];
  assign di    = (s_q < 3'd3) ? s_q[1:0] : 2'(s_q - 3'd3);

  // operand select for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (st_q)
      T_CEN: begin
        op_a = 34'($signed(e_q.nrm[s_q[1:0]]));
        op_b = 34'($signed(e_q.offset));
      end
      T_DOT: begin
        op_a = 34'($signed(e_q.nrm[di]));
        if (s_q < 3'd3) begin
          op_b = 34'(dv_q[di]);
        end else begin
          op_b = 34'($signed(seg_a_i[di])) - 34'($signed(seg_b_i[di]));
        end
      end
      T_LAM: begin
        op_a = 34'(lam_q);
        op_b = 34'($signed(seg_b_i[s_q[1:0]])) - 34'($signed(seg_a_i[s_q[1:0]]));
      end
      T_LEN: begin
        if (s_q < 3'd3) begin
          op_a = 34'(dd_q[s_q[1:0]]);
          op_b = 34'(dd_q[s_q[1:0]]);
        end else begin
          op_a = 34'(e_q.radius);
          op_b = 34'(e_q.radius);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    cen_sum = 50'($signed(seg_a_i[ci]) - $signed(seg_a_i[ci])) + 50'($signed(e_q.pos[ci]))
              + $signed(p_q[65:16]);
    if (cen_sum > SatHi) begin
      cen_o = 32'(SatHi);
    end else if (cen_sum < SatLo) begin
      cen_o = 32'(SatLo);
    end else begin
      cen_o = 32'(cen_sum);
    end
    dv_new   = 33'($signed(seg_a_i[ci])) - 33'(cen_o);
    dot_term = $signed(p_q[67:16]);
    lam_d    = 40'(dv_q[ci]) + 40'($signed(p_q[67:30]));
    an       = b_q[51] ? -a_q : a_q;
    bn       = b_q[51] ? -b_q : b_q;
    rem2     = {rem_q[50:0], 1'b0};
  end

  always_comb begin
    st_d = st_q;
    s_d  = s_q + 3'd1;
    it_d = it_q;
    case (st_q)
      T_IDLE: begin
        s_d = '0;
        if (start_i) st_d = T_CEN;
      end
      T_CEN: if (s_q == 3'd3) begin
        st_d = T_DOT;
        s_d  = '0;
      end
      T_DOT: if (s_q == 3'd6) st_d = T_CHK;
      T_CHK: begin
        s_d  = '0;
        it_d = '0;
        if (b_q == '0 || an < 0 || an > bn) st_d = T_END;
        else if (an == bn) st_d = T_LAM;
        else st_d = T_DIV;
      end
      T_DIV: begin
        s_d  = '0;
        it_d = it_q + 5'd1;
        if (it_q == DivLast) st_d = T_LAM;
      end
      T_LAM: if (s_q == 3'd3) begin
        st_d = T_LEN;
        s_d  = '0;
      end
      T_LEN: if (s_q == 3'd4) st_d = T_END;
      T_END: st_d = T_IDLE;
      default: st_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= T_IDLE;
      s_q  <= '0;
      it_q <= '0;
    end else begin
      st_q <= st_d;
      s_q  <= s_d;
      it_q <= it_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= op_a * op_b;
    case (st_q)
      T_IDLE: if (start_i) e_q <= entry_i;
      T_CEN: begin
        a_q <= '0;
        b_q <= '0;
        if (s_q != 3'd0) dv_q[ci] <= dv_new;
      end
      T_DOT: if (s_q != 3'd0) begin
        if (s_dec < 3'd3) a_q <= a_q + dot_term;
        else b_q <= b_q + dot_term;
      end
      T_CHK: begin
        a_q   <= an;
        b_q   <= bn;
        rem_q <= 52'(an);
        lam_q <= (an == bn) ? LamOne : '0;
        ovf_q <= 1'b0;
        len_q <= '0;
        blk_q <= 1'b0;
      end
      T_DIV: begin
        if (rem2 >= 52'(b_q)) begin
          rem_q <= rem2 - 52'(b_q);
          lam_q <= {lam_q[29:0], 1'b1};
        end else begin
          rem_q <= rem2;
          lam_q <= {lam_q[29:0], 1'b0};
        end
      end
      T_LAM: if (s_q != 3'd0) begin
        dd_q[ci] <= 32'(lam_d);
        if (lam_d >= 40'sh80000000 || lam_d <= -40'sh80000000) ovf_q <= 1'b1;
      end
      T_LEN: begin
        if (s_q == 3'd4) begin
          blk_q <= !ovf_q && (len_q < 64'(r2_q));
        end else if (s_q == 3'd3) begin
          len_q <= len_q + p_q[63:0];
          r2_q  <= 62'(e_q.radius) * 62'(e_q.radius);
        end else if (s_q != 3'd0) begin
          len_q <= len_q + p_q[63:0];
        end
      end
      default: ;
    endcase
  end

  assign rsp_o.done   = (st_q == T_END);
  assign rsp_o.blocks = blk_q;

endmodule

// ===== rtl/segment_crack_disk_occlusion_unit.sv =====
// Segment crack disk occlusion block: top level with scan control and result register.
// Depends on scdo_pkg, scdo_if, scdo_cell and scdo_test.
//
// Use: commands arrive on in_i. Write position/crack data, write normal and
// set segment start give no result. A query gives the segment end point and
// a count; one result (is_visible, blocking_entry) leaves on out_o. The entry
// table is a ring of cells that rotates past one disk test unit; a query
// rotates the ring MAX_NEIGHBORS steps so entries return to their home cells.
// For each tested broken entry up to and including the first blocking one,
// the scan waits while the disk test unit runs the shared multiplier and the
// 30-step lambda divider (the divider is skipped when lambda is one, and the
// entry is rejected before the divider when the plane test fails).
// Only one command is in work at a time; ready is high while no query runs.
// The result register holds a finished result while out_o is stalled and new
// writes are still taken; a second query scans and then holds, with ready
// low, until that result drains. Reset clears control state and the segment
// start to zero; entries are undefined until written.
module segment_crack_disk_occlusion_unit import scdo_pkg::*; #(
  parameter int unsigned MAX_NEIGHBORS = 64,
  parameter int unsigned COORD_BITS    = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  scdo_in_if.sink     in_i,
  scdo_out_if.source  out_o
);

  localparam int unsigned CentreW = (COORD_BITS < 32) ? COORD_BITS : 32;
  localparam int unsigned PosW    = $clog2(MAX_NEIGHBORS + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_TEST = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e st_q, st_d;
  logic [PosW-1:0] pos_q, pos_d, cnt_q, cnt_d;
  logic            found_q, found_d;
  logic [IndexW-1:0] blk_q, blk_d;
  vec_t seg_a_q, seg_a_d, seg_b_q;
  logic out_valid_q, out_valid_d, out_vis_q;
  logic [IndexW-1:0] out_blk_q;

  logic   accept, shift, start, wr_ok, load_out;
  entry_t wdata;
  entry_t chain [MAX_NEIGHBORS];
  test_rsp_t rsp;

  assign in_i.ready = (st_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign wr_ok      = accept && (32'(in_i.entry_index) < MAX_NEIGHBORS);

  always_comb begin
    wdata.pos    = {in_i.vec_z, in_i.vec_y, in_i.vec_x};
    wdata.nrm    = {in_i.vec_z, in_i.vec_y, in_i.vec_x};
    wdata.radius = in_i.crack_radius_in;
    wdata.offset = in_i.crack_offset_in;
    wdata.broken = in_i.broken_in;
  end

  for (genvar i = 0; i < MAX_NEIGHBORS; i++) begin : g_cell
    scdo_cell u_cell (
      .clk_i    (clk_i),
      .shift_i  (shift),
      .next_i   (chain[(i + 1) % MAX_NEIGHBORS]),
      .wr_pos_i (wr_ok && in_i.command == CMD_WR_POS && 32'(in_i.entry_index) == i),
      .wr_nrm_i (wr_ok && in_i.command == CMD_WR_NRM && 32'(in_i.entry_index) == i),
      .wdata_i  (wdata),
      .entry_o  (chain[i])
    );
  end

  scdo_test #(.CentreW(CentreW)) u_test (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .entry_i (chain[0]),
    .seg_a_i (seg_a_q),
    .seg_b_i (seg_b_q),
    .rsp_o   (rsp)
  );

  always_comb begin
    st_d     = st_q;
    pos_d    = pos_q;
    cnt_d    = cnt_q;
    found_d  = found_q;
    blk_d    = blk_q;
    seg_a_d  = seg_a_q;
    shift    = 1'b0;
    start    = 1'b0;
    load_out = 1'b0;
    case (st_q)
      ST_IDLE: if (accept) begin
        if (in_i.command == CMD_SET_START) begin
          seg_a_d = {in_i.vec_z, in_i.vec_y, in_i.vec_x};
        end else if (in_i.command == CMD_QUERY) begin
          st_d    = ST_SCAN;
          pos_d   = '0;
          found_d = 1'b0;
          blk_d   = '0;
          if (32'(in_i.test_count) > MAX_NEIGHBORS) cnt_d = PosW'(MAX_NEIGHBORS);
          else cnt_d = PosW'(in_i.test_count);
        end
      end
      ST_SCAN: begin
        if (32'(pos_q) == MAX_NEIGHBORS) begin
          st_d = ST_DONE;
        end else if (pos_q < cnt_q && !found_q && chain[0].broken) begin
          start = 1'b1;
          st_d  = ST_TEST;
        end else begin
          shift = 1'b1;
          pos_d = pos_q + 1'b1;
        end
      end
      ST_TEST: if (rsp.done) begin
        if (rsp.blocks) begin
          found_d = 1'b1;
          blk_d   = IndexW'(pos_q);
        end
        shift = 1'b1;
        pos_d = pos_q + 1'b1;
        st_d  = ST_SCAN;
      end
      ST_DONE: if (!out_valid_q || out_o.ready) begin
        load_out = 1'b1;
        st_d     = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // hold a result until its transfer, refill in the same cycle
  assign out_valid_d = load_out || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      pos_q       <= '0;
      cnt_q       <= '0;
      found_q     <= 1'b0;
      seg_a_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      found_q     <= found_d;
      seg_a_q     <= seg_a_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
    if (accept && in_i.command == CMD_QUERY) begin
      seg_b_q <= {in_i.vec_z, in_i.vec_y, in_i.vec_x};
    end
    if (load_out) begin
      out_vis_q <= !found_q;
      out_blk_q <= found_q ? blk_q : '0;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.is_visible     = out_vis_q;
  assign out_o.blocking_entry = out_blk_q;

endmodule

// ===== dv/tb_segment_crack_disk_occlusion_unit.sv =====
// Testbench for segment_crack_disk_occlusion_unit: random and directed command traffic,
// and a scoreboard that predicts each query answer from its own copy of the entry table.
// Depends on rtl/scdo_pkg.sv, rtl/scdo_if.sv and the RTL of the block.
module tb_segment_crack_disk_occlusion_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import scdo_pkg::*;

  localparam int unsigned NumEntries = 64;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    cmd_e               command;
    logic [5:0]         entry_index;
    logic [6:0]         test_count;
    logic signed [31:0] vec[3];
    logic [30:0]        radius;
    logic signed [31:0] offset;
    logic               broken;
  } cmd_item_t;

  typedef struct {
    logic       is_visible;
    logic [5:0] blocking_entry;
  } answer_t;

  class occlusion_scoreboard;
    logic signed [31:0] pos_tbl[NumEntries][3];
    logic signed [31:0] nrm_tbl[NumEntries][3];
    logic [30:0]        radius_tbl[NumEntries];
    logic signed [31:0] offset_tbl[NumEntries];
    logic               broken_tbl[NumEntries];
    logic signed [31:0] seg_start[3];
    answer_t            answers_due[$];
    int                 errors;

    function new();
      errors = 0;
      for (int k = 0; k < 3; k++) seg_start[k] = '0;
    endfunction

    // Does the segment from seg_start to the end point cross the disk of entry e?
    function bit disk_crossed(int e, logic signed [31:0] pend[3]);
      wide_t c, a_sum, b_sum, lam, d, len2, r2, lim, n, s, p;
      wide_t dv[3];
      a_sum = 0;
      b_sum = 0;
      len2  = 0;
      lim   = wide_t'(1) <<< 31;
      for (int k = 0; k < 3; k++) begin
        n = nrm_tbl[e][k];
        p = pos_tbl[e][k];
        s = seg_start[k];
        c = offset_tbl[e];
        c = p + ((n * c) >>> FracBits);
        if (c > lim - 1) c = lim - 1;
        if (c < -lim) c = -lim;
        dv[k] = s - c;
        p = pend[k];
        a_sum += (n * dv[k]) >>> FracBits;
        b_sum += (n * (s - p)) >>> FracBits;
      end
      // plane parallel to the segment: skip
      if (b_sum == 0) return 0;
      if (b_sum < 0) begin
        a_sum = -a_sum;
        b_sum = -b_sum;
      end
      if (a_sum < 0 || a_sum > b_sum) return 0;
      lam = (a_sum == b_sum) ? (wide_t'(1) <<< LambdaBits) : ((a_sum <<< LambdaBits) / b_sum);
      for (int k = 0; k < 3; k++) begin
        s = seg_start[k];
        p = pend[k];
        d = dv[k] + ((lam * (p - s)) >>> LambdaBits);
        if (d >= lim || d <= -lim) return 0;
        len2 += d * d;
      end
      r2 = {97'b0, radius_tbl[e]};
      r2 = r2 * r2;
      return len2 < r2;
    endfunction

    function void note_input(cmd_item_t it);
      int cnt;
      answer_t ans;
      case (it.command)
        CMD_WR_POS: begin
          for (int k = 0; k < 3; k++) pos_tbl[it.entry_index][k] = it.vec[k];
          radius_tbl[it.entry_index] = it.radius;
          offset_tbl[it.entry_index] = it.offset;
          broken_tbl[it.entry_index] = it.broken;
        end
        CMD_WR_NRM: begin
          for (int k = 0; k < 3; k++) nrm_tbl[it.entry_index][k] = it.vec[k];
        end
        CMD_SET_START: begin
          for (int k = 0; k < 3; k++) seg_start[k] = it.vec[k];
        end
        default: begin
          cnt = (it.test_count > NumEntries) ? NumEntries : it.test_count;
          ans.is_visible     = 1'b1;
          ans.blocking_entry = '0;
          for (int e = 0; e < cnt; e++) begin
            if (broken_tbl[e] && disk_crossed(e, it.vec)) begin
              ans.is_visible     = 1'b0;
              ans.blocking_entry = e[5:0];
              break;
            end
          end
          answers_due = {answers_due, ans};
        end
      endcase
    endfunction

    function void check_answer(logic vis, logic [5:0] blk);
      answer_t exp_ans;
      if (answers_due.size() == 0) begin
        $error("unexpected result: is_visible %0b blocking_entry %0d", vis, blk);
        errors++;
        return;
      end
      exp_ans = answers_due.pop_front();
      if (vis !== exp_ans.is_visible) begin
        $error("is_visible: expected %0b, got %0b", exp_ans.is_visible, vis);
        errors++;
      end
      if (blk !== exp_ans.blocking_entry) begin
        $error("blocking_entry: expected %0d, got %0d", exp_ans.blocking_entry, blk);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  scdo_in_if  cmd_ch ();
  scdo_out_if ans_ch ();

  segment_crack_disk_occlusion_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_ch.sink),
    .out_o  (ans_ch.source)
  );

  occlusion_scoreboard board = new();
  int burst_left = 0;
  int stall_mode = 0;

  always #1 clk_i = ~clk_i;

  initial begin
    cmd_ch.valid           = 1'b0;
    cmd_ch.command         = CMD_WR_POS;
    cmd_ch.entry_index     = '0;
    cmd_ch.test_count      = '0;
    cmd_ch.vec_x           = '0;
    cmd_ch.vec_y           = '0;
    cmd_ch.vec_z           = '0;
    cmd_ch.crack_radius_in = '0;
    cmd_ch.crack_offset_in = '0;
    cmd_ch.broken_in       = 1'b0;
    ans_ch.ready           = 1'b0;
  end

  // receiver stalls in phases: always ready, sparse stalls, heavy stalls
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0:       ans_ch.ready <= 1'b1;
        1:       ans_ch.ready <= ($urandom_range(0, 7) != 0);
        default: ans_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && ans_ch.valid && ans_ch.ready)
      board.check_answer(ans_ch.is_visible, ans_ch.blocking_entry);
  end

  function automatic logic signed [31:0] coord(bit wide);
    if (wide) return $urandom;
    return $signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000;
  endfunction

  function automatic logic signed [31:0] nrm_comp();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
  endfunction

  // Present one item at the falling edge, hold it until the transfer, then idle a while unless a burst goes on.
  task automatic send_cmd(cmd_item_t it);
    cmd_ch.valid           = 1'b1;
    cmd_ch.command         = it.command;
    cmd_ch.entry_index     = it.entry_index;
    cmd_ch.test_count      = it.test_count;
    cmd_ch.vec_x           = it.vec[0];
    cmd_ch.vec_y           = it.vec[1];
    cmd_ch.vec_z           = it.vec[2];
    cmd_ch.crack_radius_in = it.radius;
    cmd_ch.crack_offset_in = it.offset;
    cmd_ch.broken_in       = it.broken;
    do @(posedge clk_i); while (!cmd_ch.ready);
    board.note_input(it);
    @(negedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      cmd_ch.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  function automatic cmd_item_t blank_item(cmd_e c);
    cmd_item_t it;
    it.command     = c;
    it.entry_index = 6'($urandom);
    it.test_count  = 7'($urandom);
    for (int k = 0; k < 3; k++) it.vec[k] = $urandom;
    it.radius      = 31'($urandom);
    it.offset      = $urandom;
    it.broken      = 1'($urandom);
    return it;
  endfunction

  function automatic cmd_item_t pos_item(int idx, bit wide);
    cmd_item_t it;
    it = blank_item(CMD_WR_POS);
    it.entry_index = 6'(idx);
    for (int k = 0; k < 3; k++) it.vec[k] = coord(wide);
    it.radius = wide ? 31'($urandom) : 31'($urandom_range(0, 32'h0008_0000));
    it.offset = wide ? 32'($urandom) : $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
    it.broken = ($urandom_range(0, 3) != 0);
    return it;
  endfunction

  function automatic cmd_item_t nrm_item(int idx);
    cmd_item_t it;
    it = blank_item(CMD_WR_NRM);
    it.entry_index = 6'(idx);
    for (int k = 0; k < 3; k++) it.vec[k] = nrm_comp();
    return it;
  endfunction

  function automatic cmd_item_t vec_item(cmd_e c, logic signed [31:0] x, logic signed [31:0] y,
                                         logic signed [31:0] z, int cnt);
    cmd_item_t it;
    it = blank_item(c);
    it.entry_index = '0;
    it.vec[0] = x;
    it.vec[1] = y;
    it.vec[2] = z;
    it.test_count = 7'(cnt);
    return it;
  endfunction

  function automatic cmd_item_t disk_item(int idx, logic signed [31:0] x, logic [30:0] r,
                                          logic signed [31:0] off, logic brk);
    cmd_item_t it;
    it = blank_item(CMD_WR_POS);
    it.entry_index = 6'(idx);
    it.vec[0] = x;
    it.vec[1] = 0;
    it.vec[2] = 0;
    it.radius = r;
    it.offset = off;
    it.broken = brk;
    return it;
  endfunction

  localparam logic signed [31:0] One    = 32'sh0001_0000;
  localparam logic signed [31:0] MaxPos = 32'sh7fff_ffff;
  localparam logic signed [31:0] MinNeg = 32'sh8000_0000;

  initial begin
    cmd_item_t it;
    int sel;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // fill the whole table so no query reads an unwritten entry
    for (int e = 0; e < NumEntries; e++) begin
      send_cmd(pos_item(e, e % 8 == 7));
      send_cmd(nrm_item(e));
    end

    // disk at origin, normal along x, crossed by a segment along x
    send_cmd(disk_item(0, 0, 31'(One), 0, 1'b1));
    send_cmd(vec_item(CMD_WR_NRM, One, 0, 0, 0));
    send_cmd(vec_item(CMD_SET_START, -One, 0, 0, 0));
    send_cmd(vec_item(CMD_QUERY, One, 0, 0, 64));
    send_cmd(vec_item(CMD_QUERY, One, 0, 0, 0));
    send_cmd(vec_item(CMD_QUERY, One, 0, 0, 127));
    send_cmd(vec_item(CMD_QUERY, One, 0, 0, 65));
    // segment ends on the plane: lambda is one
    send_cmd(vec_item(CMD_QUERY, 0, 0, 0, 1));
    // segment stops short of the plane
    send_cmd(vec_item(CMD_QUERY, -(One >>> 1), 0, 0, 1));
    // parallel segment is skipped
    send_cmd(vec_item(CMD_SET_START, 0, -One, 0, 0));
    send_cmd(vec_item(CMD_QUERY, 0, One, 0, 1));
    // disk shifted by the offset along the normal, then a zero radius disk, then an entry that is not broken
    send_cmd(disk_item(0, 0, 31'(One), 32'sh0003_0000, 1'b1));
    send_cmd(vec_item(CMD_SET_START, 32'sh0002_0000, 0, 0, 0));
    send_cmd(vec_item(CMD_QUERY, 32'sh0004_0000, 0, 0, 1));
    send_cmd(disk_item(0, 0, '0, 0, 1'b1));
    send_cmd(vec_item(CMD_QUERY, 32'sh8000_0000, 0, 0, 64));
    send_cmd(disk_item(0, MaxPos, 31'h7fff_ffff, MinNeg, 1'b0));
    // extreme start and end points
    send_cmd(vec_item(CMD_SET_START, MaxPos, MinNeg, MaxPos, 0));
    send_cmd(vec_item(CMD_QUERY, MinNeg, MaxPos, MinNeg, 64));
    send_cmd(vec_item(CMD_WR_NRM, MaxPos, MinNeg, MinNeg, 0));
    send_cmd(vec_item(CMD_QUERY, MaxPos, MaxPos, MaxPos, 64));

    // hold until every answer has drained
    cmd_ch.valid = 1'b0;
    while (board.answers_due.size() != 0) @(negedge clk_i);

    for (int i = 0; i < 650; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        send_cmd(pos_item($urandom_range(0, NumEntries - 1), $urandom_range(0, 7) == 0));
      end else if (sel < 55) begin
        send_cmd(nrm_item($urandom_range(0, NumEntries - 1)));
      end else if (sel < 65) begin
        send_cmd(vec_item(CMD_SET_START, coord($urandom_range(0, 7) == 0),
                          coord($urandom_range(0, 7) == 0), coord($urandom_range(0, 7) == 0), 0));
      end else begin
        it = vec_item(CMD_QUERY, coord($urandom_range(0, 7) == 0),
                      coord($urandom_range(0, 7) == 0), coord($urandom_range(0, 7) == 0), 0);
        it.test_count = ($urandom_range(0, 4) == 0) ? 7'($urandom) : 7'($urandom_range(0, 24));
        send_cmd(it);
      end
      if (i == 325) begin
        cmd_ch.valid = 1'b0;
        while (board.answers_due.size() != 0) @(negedge clk_i);
      end
    end

    cmd_ch.valid = 1'b0;
    while (board.answers_due.size() != 0) @(negedge clk_i);
    repeat (200) @(posedge clk_i);
    if (board.errors == 0)
      $display("tb_segment_crack_disk_occlusion_unit passed");
    else
      $display("tb_segment_crack_disk_occlusion_unit failed");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("tb_segment_crack_disk_occlusion_unit failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/scdo_pkg.sv
rtl/scdo_if.sv
rtl/scdo_cell.sv
rtl/scdo_test.sv
rtl/segment_crack_disk_occlusion_unit.sv
dv/tb_segment_crack_disk_occlusion_unit.sv
